// ----- rtl/generational_handle_allocator_unit_macros.svh -----
// ----------------------------------------------------------------------------
// generational_handle_allocator_unit_macros
// Assertion helpers for the handle allocator.
// ----------------------------------------------------------------------------
// Each macro expects clk and rst in scope.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_UNIT_MACROS_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_UNIT_MACROS_SVH

// Consequent in the same cycle.
`define GHA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent in the next cycle.
`define GHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/gha_pkg.sv -----
// ----------------------------------------------------------------------------
// gha_pkg
// Types and constants shared by the generational handle allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package gha_pkg;

  localparam int SLOTS = 1024;
  localparam int IDX_W = 10;
  localparam int ROW_W = 5;
  localparam int BIT_W = 5;
  localparam int ROWS  = SLOTS / 32;
  localparam int CNT_W = 11;
  localparam int GEN_W = 16;

  localparam logic [2:0] OP_CLAIM   = 3'd0;
  localparam logic [2:0] OP_RELEASE = 3'd1;
  localparam logic [2:0] OP_CHECK   = 3'd2;
  localparam logic [2:0] OP_FIRST   = 3'd3;
  localparam logic [2:0] OP_NEXT    = 3'd4;
  localparam logic [2:0] OP_ID      = 3'd5;
  localparam logic [2:0] OP_CLEAR   = 3'd6;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] slot_index;
    logic [15:0] generation;
  } request_t;

  typedef struct packed {
    logic        ok;
    logic [9:0]  result_index;
    logic [15:0] result_generation;
  } response_t;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_SCAN,
    ST_EVAL,
    ST_GREAD,
    ST_GUSE,
    ST_CREAD,
    ST_CUSE,
    ST_RREAD,
    ST_RUSE
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/generational_handle_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// generational_handle_allocator_unit
// Slot allocator that hands out index/generation handles.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single response
// appears on response for exactly one cycle with done high, and cannot be
// held off. Claim, first and next walk the in-use bitmap one 32-slot row at a
// time, each row read and then evaluated, and on a hit read the generation
// memory and use the word read. Release reads and rewrites its bitmap row,
// then walks down row by row from the highest used slot to shrink that mark.
// Check and id_from_index read their memories and then answer; an
// out-of-range or unused request answers in the next cycle. Clear sweeps all
// 1024 generation entries, one a cycle. After reset the same sweep runs with
// busy high before the first request is taken; slot_count writes land at any
// time.
`timescale 1ns / 1ps
`default_nettype none
`include "generational_handle_allocator_unit_macros.svh"
module generational_handle_allocator_unit
  import gha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire request_t    request,
  output logic             done,
  output response_t        response,
  input  wire logic        cfg_we,
  input  wire logic [10:0] cfg_wdata
);

  // Bitmap: 32 rows of 32 in-use bits. Generations: one word per slot.
  logic [31:0]      bm [ROWS];
  logic [GEN_W-1:0] gm [SLOTS];
  logic [31:0]      bm_rdata;
  logic [GEN_W-1:0] gm_rdata;

  logic             bm_we, gm_we;
  logic [ROW_W-1:0] bm_waddr;
  logic [IDX_W-1:0] gm_waddr;
  logic [31:0]      bm_wdata;
  logic [GEN_W-1:0] gm_wdata;

  state_t           state, state_next;
  logic [ROW_W-1:0] row, row_next;
  logic [CNT_W-1:0] s_lo, s_lo_next;   // scan start, or inclusive top when walking down
  logic [CNT_W-1:0] s_hi, s_hi_next;   // exclusive scan limit when walking up
  logic             dir_down, dir_down_next;
  logic             match, match_next;
  logic [IDX_W-1:0] pos, pos_next;
  logic [2:0]       cur_op, cur_op_next;
  logic [GEN_W-1:0] cur_gen, cur_gen_next;
  logic [IDX_W-1:0] hu, hu_next;
  logic [IDX_W-1:0] sweep, sweep_next;
  logic             report, report_next;
  logic [CNT_W-1:0] slot_count;
  logic             finish;
  response_t        res;

  // Active slot count, clipped to the built size.
  logic [CNT_W-1:0] cnt;
  assign cnt = (slot_count > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : slot_count;

  // Request decode helpers.
  logic             req_nz, req_inr;
  logic [16:0]      next_start;
  logic [CNT_W-1:0] next_limit;
  logic [CNT_W-1:0] hu_p1;
  assign req_nz     = (request.slot_index != 16'd0) || (request.generation != 16'd0);
  assign req_inr    = request.slot_index < {5'd0, cnt};
  assign next_start = {1'b0, request.slot_index} + 17'd1;
  assign hu_p1      = {1'b0, hu} + CNT_W'(1);
  assign next_limit = (hu_p1 < cnt) ? hu_p1 : cnt;

  // Row evaluation: mask the scan window and pick the lowest (up) or highest
  // (down) bit that matches.
  logic [31:0]      hit;
  logic             found;
  logic [BIT_W-1:0] fbit;
  logic [IDX_W-1:0] fpos;
  logic [ROW_W:0]   row_p1;
  always_comb begin
    logic [CNT_W-1:0] i;
    for (int b = 0; b < 32; b++) begin
      i = {1'b0, row, BIT_W'(b)};
      if (dir_down) begin
        hit[b] = (bm_rdata[b] == match) && (i <= s_lo);
      end else begin
        hit[b] = (bm_rdata[b] == match) && (i >= s_lo) && (i < s_hi);
      end
    end
    found = |hit;
    fbit  = '0;
    if (dir_down) begin
      for (int b = 0; b < 32; b++) begin
        if (hit[b]) fbit = BIT_W'(b);
      end
    end else begin
      for (int b = 31; b >= 0; b--) begin
        if (hit[b]) fbit = BIT_W'(b);
      end
    end
    fpos   = {row, fbit};
    row_p1 = {1'b0, row} + 6'd1;
  end

  // Generation bump, wrapping past the top back to one.
  logic [GEN_W-1:0] gen_bump;
  assign gen_bump = (gm_rdata == 16'hFFFF) ? 16'd1 : gm_rdata + 16'd1;

  always_comb begin
    state_next    = state;
    row_next      = row;
    s_lo_next     = s_lo;
    s_hi_next     = s_hi;
    dir_down_next = dir_down;
    match_next    = match;
    pos_next      = pos;
    cur_op_next   = cur_op;
    cur_gen_next  = cur_gen;
    hu_next       = hu;
    sweep_next    = sweep;
    report_next   = report;
    finish        = 1'b0;
    res           = '0;
    bm_we         = 1'b0;
    bm_waddr      = row;
    bm_wdata      = bm_rdata;
    gm_we         = 1'b0;
    gm_waddr      = pos;
    gm_wdata      = gen_bump;
    case (state)
      ST_SWEEP: begin
        // Zero one generation per cycle; the bitmap rows ride along at the start.
        gm_we    = 1'b1;
        gm_waddr = sweep;
        gm_wdata = '0;
        bm_we    = (sweep[IDX_W-1:ROW_W] == '0);
        bm_waddr = sweep[ROW_W-1:0];
        bm_wdata = '0;
        sweep_next = sweep + IDX_W'(1);
        if (sweep == IDX_W'(SLOTS - 1)) begin
          state_next = ST_IDLE;
          finish     = report;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cur_op_next   = request.op;
          cur_gen_next  = request.generation;
          dir_down_next = 1'b0;
          case (request.op)
            OP_CLAIM, OP_FIRST: begin
              s_lo_next  = '0;
              s_hi_next  = cnt;
              row_next   = '0;
              match_next = (request.op == OP_FIRST);
              if (cnt == '0) finish = 1'b1;
              else state_next = ST_SCAN;
            end
            OP_NEXT: begin
              if (next_start >= {6'd0, next_limit}) begin
                finish = 1'b1;
              end else begin
                s_lo_next  = next_start[CNT_W-1:0];
                s_hi_next  = next_limit;
                row_next   = next_start[IDX_W-1:BIT_W];
                match_next = 1'b1;
                state_next = ST_SCAN;
              end
            end
            OP_RELEASE, OP_CHECK: begin
              if (req_nz && req_inr) begin
                row_next   = request.slot_index[IDX_W-1:BIT_W];
                pos_next   = request.slot_index[IDX_W-1:0];
                state_next = (request.op == OP_RELEASE) ? ST_RREAD : ST_CREAD;
              end else begin
                finish = 1'b1;
              end
            end
            OP_ID: begin
              if (req_inr) begin
                pos_next   = request.slot_index[IDX_W-1:0];
                state_next = ST_GREAD;
              end else begin
                finish = 1'b1;
              end
            end
            OP_CLEAR: begin
              sweep_next  = '0;
              report_next = 1'b1;
              state_next  = ST_SWEEP;
            end
            default: finish = 1'b1;
          endcase
        end
      end
      ST_SCAN: state_next = ST_EVAL;
      ST_EVAL: begin
        if (dir_down) begin
          // Shrink after release: land on the highest used slot, else zero.
          if (found) begin
            hu_next    = fpos;
            finish     = 1'b1;
            state_next = ST_IDLE;
          end else if (row == '0) begin
            hu_next    = '0;
            finish     = 1'b1;
            state_next = ST_IDLE;
          end else begin
            row_next   = row - ROW_W'(1);
            state_next = ST_SCAN;
          end
        end else if (found) begin
          pos_next   = fpos;
          state_next = ST_GREAD;
          if (cur_op == OP_CLAIM) begin
            bm_we    = 1'b1;
            bm_wdata = bm_rdata | (32'd1 << fbit);
          end
        end else if ({row_p1, 5'd0} >= s_hi) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end else begin
          row_next   = row_p1[ROW_W-1:0];
          state_next = ST_SCAN;
        end
      end
      ST_GREAD: state_next = ST_GUSE;
      ST_GUSE: begin
        finish     = 1'b1;
        state_next = ST_IDLE;
        if (cur_op == OP_CLAIM) begin
          gm_we   = 1'b1;
          if (pos > hu) hu_next = pos;
          res.ok                = 1'b1;
          res.result_index      = pos;
          res.result_generation = gen_bump;
        end else begin
          res.ok                = (pos != '0) || (gm_rdata != '0);
          res.result_index      = pos;
          res.result_generation = gm_rdata;
        end
      end
      ST_CREAD: state_next = ST_CUSE;
      ST_CUSE: begin
        finish     = 1'b1;
        state_next = ST_IDLE;
        res.ok     = bm_rdata[pos[BIT_W-1:0]] && (gm_rdata == cur_gen);
      end
      ST_RREAD: state_next = ST_RUSE;
      ST_RUSE: begin
        // Drop the bit, then walk down from the highest used slot.
        bm_we         = 1'b1;
        bm_wdata      = bm_rdata & ~(32'd1 << pos[BIT_W-1:0]);
        row_next      = hu[IDX_W-1:BIT_W];
        s_lo_next     = {1'b0, hu};
        dir_down_next = 1'b1;
        match_next    = 1'b1;
        state_next    = ST_SCAN;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);

  // Memories: one write and one registered read each cycle.
  always_ff @(posedge clk) begin
    if (bm_we) bm[bm_waddr] <= bm_wdata;
    bm_rdata <= bm[row];
  end

  always_ff @(posedge clk) begin
    if (gm_we) gm[gm_waddr] <= gm_wdata;
    gm_rdata <= gm[pos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SWEEP;
      sweep      <= '0;
      report     <= 1'b0;
      hu         <= '0;
      slot_count <= CNT_W'(SLOTS);
      done       <= 1'b0;
    end else begin
      state  <= state_next;
      sweep  <= sweep_next;
      report <= report_next;
      hu     <= hu_next;
      done   <= finish;
      if (cfg_we) slot_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    row      <= row_next;
    s_lo     <= s_lo_next;
    s_hi     <= s_hi_next;
    dir_down <= dir_down_next;
    match    <= match_next;
    pos      <= pos_next;
    cur_op   <= cur_op_next;
    cur_gen  <= cur_gen_next;
    response <= res;
  end

  // A response only shows once the engine is back to idle.
  `GHA_ASSERT_NOW(a_done_idle, done, !busy, "response while busy")
  // Every accepted request either answers at once or keeps the engine busy.
  `GHA_ASSERT_NEXT(a_no_drop, start && !busy, done || busy, "request dropped")
  // Row evaluation always follows a row read.
  `GHA_ASSERT_NOW(a_eval_order, state == ST_EVAL, $past(state) == ST_SCAN,
                  "row evaluated without a read")

endmodule
`default_nettype wire

// ----- verif/generational_handle_allocator_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generational_handle_allocator_unit_tb
// Self-checking bench for the handle allocator: requests are driven with
// random gaps, and every response is checked against a behavioral allocator
// kept in the bench.
// ----------------------------------------------------------------------------
module generational_handle_allocator_unit_tb;
  import gha_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int CYCLE_LIMIT = 10000000;
  localparam int SETTLE      = 80;
  localparam logic [2:0] OP_UNUSED = 3'd7;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  request_t    request;
  logic        done;
  response_t   response;
  logic        cfg_we;
  logic [10:0] cfg_wdata;

  generational_handle_allocator_unit dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .request  (request),
    .done     (done),
    .response (response),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Allocator mirror: in-use bitmap, generations, highest used slot, count.
  logic        slot_live [SLOTS];
  logic [15:0] slot_gen [SLOTS];
  int          top_used;
  logic [10:0] slot_limit;

  response_t   pending_responses[$];
  int          mismatch_count;
  int          cycle_count;
  bit          no_gaps;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int active_slots();
    return (slot_limit > SLOTS) ? SLOTS : int'(slot_limit);
  endfunction

  function automatic response_t make_handle(int idx, logic [15:0] g);
    response_t h;
    h.ok = (idx != 0 || g != 0);
    h.result_index = idx[9:0];
    h.result_generation = g;
    return h;
  endfunction

  // Apply one request to the mirror and return the response it must give.
  function automatic response_t allocate_step(request_t r);
    response_t h;
    int cnt;
    int i;
    int idx;
    cnt = active_slots();
    idx = int'(r.slot_index);
    h = '0;
    case (r.op)
      OP_CLAIM: begin
        for (i = 0; i < cnt; i++) if (!slot_live[i]) break;
        if (i < cnt) begin
          slot_live[i] = 1'b1;
          // Wrap past zero so a live handle never carries generation 0.
          slot_gen[i] = (slot_gen[i] == 16'hFFFF) ? 16'd1 : slot_gen[i] + 16'd1;
          if (i > top_used) top_used = i;
          h = make_handle(i, slot_gen[i]);
        end
      end
      OP_RELEASE: begin
        if (!((idx == 0 && r.generation == 0) || idx >= cnt)) begin
          slot_live[idx] = 1'b0;
          while (top_used > 0 && !slot_live[top_used]) top_used--;
        end
      end
      OP_CHECK: begin
        if (!((idx == 0 && r.generation == 0) || idx >= cnt))
          h.ok = slot_live[idx] && slot_gen[idx] == r.generation;
      end
      OP_FIRST: begin
        for (i = 0; i < cnt; i++) begin
          if (slot_live[i]) begin
            h = make_handle(i, slot_gen[i]);
            break;
          end
        end
      end
      OP_NEXT: begin
        for (i = idx + 1; i <= top_used && i < cnt; i++) begin
          if (slot_live[i]) begin
            h = make_handle(i, slot_gen[i]);
            break;
          end
        end
      end
      OP_ID: begin
        if (idx < cnt) h = make_handle(idx, slot_gen[idx]);
      end
      OP_CLEAR: begin
        // Leave the highest-used mark untouched.
        for (i = 0; i < SLOTS; i++) begin
          slot_live[i] = 1'b0;
          slot_gen[i] = '0;
        end
      end
      default: ;
    endcase
    return h;
  endfunction

  // Check each response against the oldest prediction.
  always @(posedge clk) begin
    response_t want;
    if (!rst && done) begin
      if (pending_responses.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < 10)
          $display("unexpected response ok=%0b idx=%0d gen=%0d", response.ok,
                   response.result_index, response.result_generation);
      end else begin
        want = pending_responses.pop_front();
        if (response.ok !== want.ok || response.result_index !== want.result_index ||
            response.result_generation !== want.result_generation) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10)
            $display("response mismatch: want ok=%0b idx=%0d gen=%0d, got ok=%0b idx=%0d gen=%0d",
                     want.ok, want.result_index, want.result_generation, response.ok,
                     response.result_index, response.result_generation);
        end
      end
    end
  end

  // Send one request: idle for a random gap, then hold start until taken.
  task automatic send_request(logic [2:0] op, logic [15:0] idx, logic [15:0] g);
    request_t r;
    int gap;
    r.op = op;
    r.slot_index = idx;
    r.generation = g;
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    pending_responses.push_back(allocate_step(r));
  endtask

  // Drain responses, let the block settle, then write the slot count.
  task automatic set_slot_count(logic [10:0] value);
    start <= 1'b0;
    wait (pending_responses.size() == 0);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    slot_limit = value;
  endtask

  // Pick a live slot below the active count, or -1 when none is live.
  function automatic int pick_live_slot();
    int cnt;
    int base;
    int k;
    cnt = active_slots();
    if (cnt == 0) return -1;
    base = $urandom_range(0, cnt - 1);
    for (k = 0; k < cnt; k++)
      if (slot_live[(base + k) % cnt]) return (base + k) % cnt;
    return -1;
  endfunction

  // Mostly in-range indexes, with bounds and the full 16-bit range mixed in.
  function automatic logic [15:0] pick_index();
    int cnt;
    int sel;
    cnt = active_slots();
    sel = $urandom_range(0, 9);
    if (sel < 6 && cnt > 0) return 16'($urandom_range(0, cnt - 1));
    if (sel == 6) return 16'(cnt);
    if (sel == 7) return 16'(SLOTS - 1);
    if (sel == 8) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  task automatic test_directed_ops();
    no_gaps = 1'b0;
    send_request(OP_FIRST, 16'd0, 16'd0);        // walk an empty table
    send_request(OP_NEXT, 16'd0, 16'd0);
    send_request(OP_CLAIM, 16'd0, 16'd0);
    send_request(OP_CLAIM, 16'd0, 16'd0);
    send_request(OP_CLAIM, 16'd0, 16'd0);
    send_request(OP_CHECK, 16'd1, 16'd1);        // live handle
    send_request(OP_CHECK, 16'd1, 16'd2);        // stale generation
    send_request(OP_CHECK, 16'd0, 16'd0);        // zero handle
    send_request(OP_CHECK, 16'hFFFF, 16'hFFFF);  // out of range
    send_request(OP_RELEASE, 16'd0, 16'd0);      // zero handle is ignored
    send_request(OP_RELEASE, 16'd1024, 16'd1);   // out of range is ignored
    send_request(OP_RELEASE, 16'd2, 16'hFFFF);   // generation not checked
    send_request(OP_NEXT, 16'd0, 16'hFFFF);
    send_request(OP_NEXT, 16'hFFFF, 16'd0);      // must not wrap
    send_request(OP_ID, 16'd1023, 16'd0);
    send_request(OP_ID, 16'd1024, 16'd0);
    send_request(OP_UNUSED, 16'hFFFF, 16'hFFFF);
    send_request(OP_FIRST, 16'd0, 16'd0);
    // Shrink to a tiny table that is already full, then claim with nothing free.
    set_slot_count(11'd2);
    send_request(OP_CLAIM, 16'd0, 16'd0);
    send_request(OP_CLAIM, 16'd0, 16'd0);
    send_request(OP_CLAIM, 16'd0, 16'd0);
    set_slot_count(11'd0);
    send_request(OP_CLAIM, 16'd0, 16'd0);
    send_request(OP_FIRST, 16'd0, 16'd0);
    send_request(OP_ID, 16'd0, 16'd0);
    send_request(OP_CLEAR, 16'd0, 16'd0);
  endtask

  // Cycle one slot through a run of generations, back to back.
  task automatic test_generation_cycle();
    no_gaps = 1'b1;
    set_slot_count(11'd1);
    send_request(OP_CLEAR, 16'd0, 16'd0);
    repeat (50) begin
      send_request(OP_CLAIM, 16'd0, 16'd0);
      send_request(OP_RELEASE, 16'd0, slot_gen[0]);
    end
    send_request(OP_CLAIM, 16'd0, 16'd0);
    send_request(OP_CHECK, 16'd0, slot_gen[0]);
    send_request(OP_ID, 16'd0, 16'd0);
  endtask

  // Mostly well-formed claim/release/check/walk traffic, some noise.
  task automatic test_random_mix(int items);
    int n;
    int sel;
    int s;
    for (n = 0; n < items; n++) begin
      if (n % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 99);
      s = pick_live_slot();
      if (sel < 30) begin
        send_request(OP_CLAIM, 16'($urandom), 16'($urandom));
      end else if (sel < 50) begin
        if (s >= 0 && sel < 45) send_request(OP_RELEASE, 16'(s), slot_gen[s]);
        else send_request(OP_RELEASE, pick_index(), 16'($urandom));
      end else if (sel < 65) begin
        if (s >= 0 && sel < 58) send_request(OP_CHECK, 16'(s), slot_gen[s]);
        else if (s >= 0 && sel < 61) send_request(OP_CHECK, 16'(s), slot_gen[s] + 16'd1);
        else send_request(OP_CHECK, pick_index(), 16'($urandom));
      end else if (sel < 72) begin
        send_request(OP_FIRST, 16'($urandom), 16'($urandom));
      end else if (sel < 85) begin
        if (s >= 0 && sel < 80) send_request(OP_NEXT, 16'(s), 16'($urandom));
        else send_request(OP_NEXT, pick_index(), 16'($urandom));
      end else if (sel < 93) begin
        send_request(OP_ID, pick_index(), 16'($urandom));
      end else begin
        // Noise: any op code, full-range fields.
        send_request(3'($urandom), 16'($urandom), 16'($urandom));
      end
    end
  endtask

  task automatic test_slot_count_settings();
    set_slot_count(11'd1024);
    test_random_mix(400);
    set_slot_count(11'd37);
    test_random_mix(400);
    set_slot_count(11'd1);
    test_random_mix(150);
    set_slot_count(11'd2047);   // clamps to the built size
    test_random_mix(400);
    set_slot_count(11'd200);
    test_random_mix(400);
  endtask

  initial begin
    int i;
    for (i = 0; i < SLOTS; i++) begin
      slot_live[i] = 1'b0;
      slot_gen[i] = '0;
    end
    top_used = 0;
    slot_limit = 11'd1024;
    mismatch_count = 0;
    cycle_count = 0;
    no_gaps = 1'b0;
    rst <= 1'b1;
    start <= 1'b0;
    request <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_directed_ops();
    test_generation_cycle();
    test_slot_count_settings();

    // Drop start, drain, and give the block time to settle.
    start <= 1'b0;
    wait (pending_responses.size() == 0);
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
